[src/utf8v_pkg.sv]
// Shared types, codes and constants for the UTF-8 stream validator.
package utf8v_pkg;

   localparam int unsigned DataWidth   = 8;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned RspWidth    = 8;

   localparam logic [7:0] TrailMask  = 8'hc0;
   localparam logic [7:0] TrailCode  = 8'h80;
   localparam logic [7:0] Lead2Mask  = 8'he0;
   localparam logic [7:0] Lead2Code  = 8'hc0;
   localparam logic [7:0] Overlong2  = 8'h1e;
   localparam logic [7:0] Lead3Mask  = 8'hf0;
   localparam logic [7:0] Lead3Code  = 8'he0;
   localparam logic [7:0] Lead4Mask  = 8'hfc;
   localparam logic [7:0] Lead4Code  = 8'hf0;
   localparam logic [7:0] LeadE0     = 8'he0;
   localparam logic [7:0] LeadED     = 8'hed;
   localparam logic [7:0] LeadF0     = 8'hf0;
   localparam logic [7:0] LeadF4     = 8'hf4;

   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_E0    = 3'd1,
      KIND_ED    = 3'd2,
      KIND_F0    = 3'd3,
      KIND_F4    = 3'd4
   } lead_kind_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_VALID   = 3'd0,
      STATUS_INVALID = 3'd1,
      STATUS_TRUNC1  = 3'd2,
      STATUS_TRUNC2  = 3'd3,
      STATUS_TRUNC3  = 3'd4
   } status_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 end_of_buffer;
   } beat_type;

   typedef struct packed {
      logic          fault_seen;
      logic [1:0]    bytes_missing;
      lead_kind_type lead_kind;
      logic          awaiting_second;
      logic          sequence_bad;
   } scan_state_type;

   localparam scan_state_type ScanIdle = '{
      fault_seen: 1'b0, bytes_missing: 2'd0, lead_kind: KIND_PLAIN,
      awaiting_second: 1'b0, sequence_bad: 1'b0};

endpackage

[src/utf8_stream_validator_top.sv]
// Top level of the strict UTF-8 stream validator.
//
// The request channel carries one byte of a buffer per beat. The tuser bit
// says whether tdata holds a real byte; a beat without a byte leaves the
// scan state alone, so a lone such beat with tlast closes an empty buffer.
// The beat with tlast ends the buffer and yields exactly one status beat on
// the response channel: 0 valid, 1 invalid byte, 2 to 4 truncated with one
// to three bytes missing. The first fault wins and later bytes are ignored,
// but a bad byte in a sequence cut short by tlast reports as truncated.
// The block takes one request beat every cycle while req_tready is high.
// A status reaches rsp_tvalid via the input register, then the status
// register. Reset clears the valid bits of both registers and the scan
// state, so the next beat starts a new buffer. When the receiver stalls, the
// status is held in its register; bytes inside a buffer keep flowing, and
// a second tlast beat waits in the input register, deasserting req_tready.
module utf8_stream_validator_top
   import utf8v_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DataWidth-1:0] req_tdata,   // [7:0] data_byte
   input  logic                 req_tuser,   // [0] has_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspWidth-1:0]  rsp_tdata    // [2:0] status, [7:3] zero
);

   logic                   beat_valid;
   beat_type               beat;
   logic                   beat_take;
   logic                   res_valid;
   logic [StatusWidth-1:0] res_status;
   logic                   res_ready;

   utf8v_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_take  (beat_take)
   );

   utf8v_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_take  (beat_take),
      .res_valid  (res_valid),
      .res_status (res_status),
      .res_ready  (res_ready)
   );

   utf8v_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_status (res_status),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[src/utf8v_in_stage.sv]
// Input register that holds one request beat for the scanner.
module utf8v_in_stage
   import utf8v_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DataWidth-1:0] req_tdata,
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   output logic                 beat_valid,
   output beat_type             beat,
   input  logic                 beat_take
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   assign req_tready = !valid_ff || beat_take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !beat_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         beat_ff <= '{data_byte: req_tdata, has_byte: req_tuser, end_of_buffer: req_tlast};
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

[src/utf8v_scan.sv]
// Per-beat UTF-8 state update and end-of-buffer status.
module utf8v_scan
   import utf8v_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  beat_type               beat,
   output logic                   beat_take,
   output logic                   res_valid,
   output logic [StatusWidth-1:0] res_status,
   input  logic                   res_ready
);

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type upd;
   status_type     status;

   assign beat_take = beat_valid && (!beat.end_of_buffer || res_ready);
   assign res_valid = beat_valid && beat.end_of_buffer;

   always_comb begin
      logic [7:0] b;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [1:0] left;
      b    = beat.data_byte;
      lo   = 8'h80;
      hi   = 8'hbf;
      left = state_ff.bytes_missing - 2'd1;
      upd  = state_ff;
      if (beat.has_byte && !state_ff.fault_seen) begin
         if (state_ff.bytes_missing != 2'd0) begin
            if (state_ff.awaiting_second) begin
               case (state_ff.lead_kind)
                  KIND_E0: lo = 8'ha0;
                  KIND_ED: hi = 8'h9f;
                  KIND_F0: lo = 8'h90;
                  KIND_F4: hi = 8'h8f;
                  default: ;
               endcase
            end
            if (b < lo || b > hi) begin
               upd.sequence_bad = 1'b1;
            end
            upd.awaiting_second = 1'b0;
            upd.bytes_missing   = left;
            if (left == 2'd0) begin
               upd.fault_seen   = upd.sequence_bad;
               upd.sequence_bad = 1'b0;
               upd.lead_kind    = KIND_PLAIN;
            end
         end else if (b[7] == 1'b0) begin
            upd = state_ff;
         end else if ((b & Lead2Mask) == Lead2Code) begin
            if ((b & Overlong2) == 8'h00) begin
               upd.fault_seen = 1'b1;
            end else begin
               upd.bytes_missing   = 2'd1;
               upd.lead_kind       = KIND_PLAIN;
               upd.awaiting_second = 1'b1;
               upd.sequence_bad    = 1'b0;
            end
         end else if ((b & Lead3Mask) == Lead3Code) begin
            upd.bytes_missing   = 2'd2;
            upd.lead_kind       = (b == LeadE0) ? KIND_E0 :
                                  (b == LeadED) ? KIND_ED : KIND_PLAIN;
            upd.awaiting_second = 1'b1;
            upd.sequence_bad    = 1'b0;
         end else if ((b & Lead4Mask) == Lead4Code) begin
            upd.bytes_missing   = 2'd3;
            upd.lead_kind       = (b == LeadF0) ? KIND_F0 : KIND_PLAIN;
            upd.awaiting_second = 1'b1;
            upd.sequence_bad    = 1'b0;
         end else if (b == LeadF4) begin
            upd.bytes_missing   = 2'd3;
            upd.lead_kind       = KIND_F4;
            upd.awaiting_second = 1'b1;
            upd.sequence_bad    = 1'b0;
         end else begin
            upd.fault_seen = 1'b1;
         end
      end
   end

   always_comb begin
      if (upd.fault_seen) begin
         status = STATUS_INVALID;
      end else begin
         case (upd.bytes_missing)
            2'd1:    status = STATUS_TRUNC1;
            2'd2:    status = STATUS_TRUNC2;
            2'd3:    status = STATUS_TRUNC3;
            default: status = STATUS_VALID;
         endcase
      end
   end

   assign res_status = status;
   assign state_in   = beat.end_of_buffer ? ScanIdle : upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ScanIdle;
      end else if (beat_take) begin
         state_ff <= state_in;
      end
   end

endmodule

[src/utf8v_out_stage.sv]
// Output register that holds one status beat until the receiver takes it.
module utf8v_out_stage
   import utf8v_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  logic [StatusWidth-1:0] res_status,
   output logic                   res_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspWidth-1:0]    rsp_tdata
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [StatusWidth-1:0] status_ff;

   assign res_ready = !valid_ff || rsp_tready;
   assign valid_in  = (res_valid && res_ready) || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         status_ff <= res_status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspWidth - StatusWidth){1'b0}}, status_ff};

endmodule

[src/utf8v_checker.sv]
// Port-level checks for the UTF-8 stream validator and their binding.
module utf8v_checker
   import utf8v_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RspWidth-1:0]  rsp_tdata
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RspWidth-1:StatusWidth] == '0 &&
                      rsp_tdata[StatusWidth-1:0] <= STATUS_TRUNC3))
      else $error("Status beat carries an undefined code.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Status beat present right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled status beat changed or dropped.");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!req_tvalid) && !$past(reset) |-> req_tready)
      else $error("Request side stalled with nothing pending.");

endmodule

bind utf8_stream_validator_top utf8v_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
